// File: design/crdp_pkg.sv
// ----------------------------------------------------------------------------
// crdp_pkg
// Shared types and constants of the clock replacement block with dirty pass.
// ----------------------------------------------------------------------------
package crdp_pkg;

  localparam int unsigned MaxFrames  = 64;
  localparam int unsigned FrameIdxW  = $clog2(MaxFrames);
  localparam int unsigned CountW     = FrameIdxW + 1;
  localparam int unsigned ReqDepth   = 15;
  localparam int unsigned ReqW       = $clog2(ReqDepth + 1);
  localparam int unsigned SweepW     = 2;
  localparam int unsigned LastSweep  = 2;
  localparam int unsigned CfgW       = 7;
  localparam int unsigned FramesRst  = 64;

  typedef enum logic [1:0] {
    KindAccess  = 2'd0,
    KindUnpin   = 2'd1,
    KindNewPage = 2'd2,
    KindVictim  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RdInput = 2'd0,
    RdHand  = 2'd1,
    RdNext  = 2'd2
  } rd_sel_e;

  // One frame's state as it sits in the state RAM.
  typedef struct packed {
    logic            refb;
    logic            pin;
    logic [ReqW-1:0] pend;
    logic [ReqW-1:0] dirty;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_item;
    logic    wr_clear_ref;
    logic    adv_init;
    logic    adv_step;
    logic    adv_wrap;
    logic    adv_count;
    logic    sw_init;
    logic    sw_next;
    logic    sw_count;
    logic    emit_found;
    logic    emit_none;
  } dp_cmd_t;

  typedef struct packed {
    logic  in_valid;
    kind_e in_kind;
    logic  in_range;
    logic  item_new;
    logic  pinned;
    logic  refb;
    logic  dirty_nz;
    logic  land;
    logic  land_at_start;
    logic  adv_last;
    logic  sw_at_start;
    logic  sw_last;
    logic  last_sweep;
    logic  out_full;
  } dp_status_t;

endpackage

// File: design/crdp_if.sv
// ----------------------------------------------------------------------------
// crdp_if
// Valid/ready channels of the clock replacement block: request items,
// victim results and the frame count register write.
// ----------------------------------------------------------------------------
interface crdp_item_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [crdp_pkg::FrameIdxW-1:0] frame_index;
  logic                           is_write;
  logic                           pin_request;

  modport source (output valid, kind, frame_index, is_write, pin_request, input ready);
  modport sink   (input valid, kind, frame_index, is_write, pin_request, output ready);
endinterface

interface crdp_result_if;
  logic                           valid;
  logic                           ready;
  logic                           victim_found;
  logic [crdp_pkg::FrameIdxW-1:0] victim_frame;
  logic                           victim_dirty;

  modport source (output valid, victim_found, victim_frame, victim_dirty, input ready);
  modport sink   (input valid, victim_found, victim_frame, victim_dirty, output ready);
endinterface

interface crdp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [crdp_pkg::CfgW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: design/crdp_ram.sv
// ----------------------------------------------------------------------------
// crdp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module crdp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/crdp_ctrl.sv
// ----------------------------------------------------------------------------
// crdp_ctrl
// Sequencer of the clock replacement block: request updates, the hand
// advance loop and the three victim sweeps.
// ----------------------------------------------------------------------------
module crdp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crdp_pkg::dp_status_t status_i,
  output crdp_pkg::dp_cmd_t    cmd_o
);
  import crdp_pkg::*;

  typedef enum logic [7:0] {
    StIdle    = 8'b0000_0001,
    StItemUpd = 8'b0000_0010,
    StVRead   = 8'b0000_0100,
    StVEval   = 8'b0000_1000,
    StAdvStep = 8'b0001_0000,
    StAdvWrap = 8'b0010_0000,
    StAdvEval = 8'b0100_0000,
    StVPost   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   victim_q, victim_d;
  logic   hit_q, hit_d;
  logic   take;

  assign take = !status_i.pinned && !status_i.refb &&
                (!status_i.dirty_nz || status_i.last_sweep);

  always_comb begin
    cmd_o    = '0;
    cmd_o.rd_sel = RdHand;
    state_d  = state_q;
    victim_d = victim_q;
    hit_d    = hit_q;
    unique case (state_q)
      StIdle: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          cmd_o.capture = 1'b1;
          hit_d = 1'b0;
          if (status_i.in_kind == KindVictim) begin
            cmd_o.sw_init = 1'b1;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_sel  = RdHand;
            victim_d      = 1'b1;
            state_d       = StVEval;
          end else if (status_i.in_range) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RdInput;
            victim_d     = 1'b0;
            state_d      = StItemUpd;
          end
        end
      end
      StItemUpd: begin
        cmd_o.wr_item = 1'b1;
        if (status_i.item_new) begin
          cmd_o.adv_init = 1'b1;
          state_d = StAdvStep;
        end else begin
          state_d = StIdle;
        end
      end
      StVRead: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RdHand;
        state_d      = StVEval;
      end
      StVEval: begin
        if (take) begin
          if (!status_i.out_full) begin
            cmd_o.emit_found = 1'b1;
            state_d = StIdle;
          end
        end else begin
          cmd_o.wr_clear_ref = !status_i.pinned && status_i.refb;
          cmd_o.adv_init     = 1'b1;
          state_d            = StAdvStep;
        end
      end
      StAdvStep, StAdvWrap: begin
        cmd_o.adv_step = (state_q == StAdvStep);
        cmd_o.adv_wrap = (state_q == StAdvWrap);
        cmd_o.rd_en    = status_i.land;
        cmd_o.rd_sel   = RdNext;
        if (status_i.land) begin
          if (status_i.land_at_start) begin
            hit_d   = 1'b0;
            state_d = victim_q ? StVPost : StIdle;
          end else begin
            state_d = StAdvEval;
          end
        end else begin
          state_d = StAdvWrap;
        end
      end
      StAdvEval: begin
        if (!status_i.pinned) begin
          hit_d   = 1'b1;
          state_d = victim_q ? StVPost : StIdle;
        end else if (status_i.adv_last) begin
          hit_d   = 1'b0;
          state_d = victim_q ? StVPost : StIdle;
        end else begin
          cmd_o.adv_count = 1'b1;
          state_d = StAdvStep;
        end
      end
      StVPost: begin
        // The read data still holds the frame under the hand when the advance
        // stopped on an unpinned frame, so the next look skips the read.
        if (status_i.sw_at_start || status_i.sw_last) begin
          if (status_i.last_sweep) begin
            if (!status_i.out_full) begin
              cmd_o.emit_none = 1'b1;
              state_d = StIdle;
            end
          end else begin
            cmd_o.sw_next = 1'b1;
            state_d = hit_q ? StVEval : StVRead;
          end
        end else begin
          cmd_o.sw_count = 1'b1;
          state_d = hit_q ? StVEval : StVRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      victim_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      victim_q <= victim_d;
      hit_q    <= hit_d;
    end
  end

endmodule

// File: design/crdp_dp.sv
// ----------------------------------------------------------------------------
// crdp_dp
// Datapath of the clock replacement block: frame state RAM with valid bits,
// hand and sweep registers, modular hand step and the result register.
// ----------------------------------------------------------------------------
module crdp_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  crdp_item_if.sink            item_i,
  crdp_result_if.source        result_o,
  crdp_cfg_if.sink             cfg_i,
  input  crdp_pkg::dp_cmd_t    cmd_i,
  output crdp_pkg::dp_status_t status_o
);
  import crdp_pkg::*;

  logic [CfgW-1:0]      frames_q;
  logic [CountW-1:0]    n;
  logic [FrameIdxW-1:0] frame_q;
  kind_e                kind_q;
  logic                 wr_q;
  logic                 pin_q;
  logic [FrameIdxW-1:0] hand_q, hand_d;
  logic [FrameIdxW-1:0] adv_start_q;
  logic [CountW-1:0]    adv_steps_q;
  logic [FrameIdxW-1:0] sw_start_q;
  logic [CountW-1:0]    sw_steps_q;
  logic [SweepW-1:0]    sweep_q;
  logic [CountW-1:0]    wrap_q, wrap_d;
  logic [MaxFrames-1:0] valid_q;
  logic                 rd_valid_q;
  logic                 out_valid_q;
  logic                 res_found_q;
  logic [FrameIdxW-1:0] res_frame_q;
  logic                 res_dirty_q;

  logic [CountW-1:0]    t;
  logic [CountW-1:0]    t1;
  logic [CountW-1:0]    cand;
  logic [FrameIdxW-1:0] rd_addr;
  logic [FrameIdxW-1:0] wr_addr;
  logic                 wr_en;
  logic [EntryW-1:0]    ram_rdata;
  entry_t               ent;
  entry_t               upd;
  entry_t               wdata;
  logic [ReqW-1:0]      pend_inc;

  // Register values outside 1..MaxFrames act as the nearest bound.
  always_comb begin
    if (frames_q == '0) begin
      n = CountW'(1);
    end else if (CountW'(frames_q) > CountW'(MaxFrames)) begin
      n = CountW'(MaxFrames);
    end else begin
      n = CountW'(frames_q);
    end
  end

  // A hand left above a lowered frame count may need several subtractions
  // to wrap; the first one is folded into the step, the rest run in wrap_q.
  assign t    = {1'b0, hand_q} + CountW'(1);
  assign t1   = (t >= n) ? (t - n) : t;
  assign cand = cmd_i.adv_wrap ? wrap_q : t1;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RdInput: rd_addr = item_i.frame_index;
      RdHand:  rd_addr = hand_q;
      RdNext:  rd_addr = cand[FrameIdxW-1:0];
      default: rd_addr = hand_q;
    endcase
  end

  crdp_ram #(
    .Width(EntryW),
    .Depth(MaxFrames)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // A frame never written since reset reads as all zero.
  assign ent = rd_valid_q ? entry_t'(ram_rdata) : entry_t'('0);

  assign pend_inc = (ent.pend >= ReqW'(ReqDepth)) ? ent.pend : ent.pend + ReqW'(1);

  always_comb begin
    upd = ent;
    if (kind_q == KindUnpin) begin
      if (ent.pend != '0) begin
        upd.pend = ent.pend - ReqW'(1);
      end
      if (ent.dirty != '0) begin
        upd.dirty = ent.dirty - ReqW'(1);
      end
    end else begin
      upd.refb = 1'b1;
      upd.pend = pend_inc;
      if (wr_q) begin
        upd.dirty = pend_inc;
      end
      upd.pin = ent.pin ? 1'b0 : pin_q;
    end
  end

  always_comb begin
    wdata = ent;
    if (cmd_i.wr_item) begin
      wdata = upd;
    end else begin
      wdata.refb = 1'b0;
    end
  end

  assign wr_en   = cmd_i.wr_item || cmd_i.wr_clear_ref;
  assign wr_addr = cmd_i.wr_item ? frame_q : hand_q;

  always_comb begin
    hand_d = hand_q;
    wrap_d = wrap_q;
    if (cmd_i.adv_step || cmd_i.adv_wrap) begin
      if (cand < n) begin
        hand_d = cand[FrameIdxW-1:0];
      end else begin
        wrap_d = cand - n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= CfgW'(FramesRst);
      hand_q      <= '0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      adv_steps_q <= '0;
      sw_steps_q  <= '0;
      sweep_q     <= '0;
    end else begin
      if (cfg_i.valid) begin
        frames_q <= cfg_i.data;
      end
      hand_q <= hand_d;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
      if (cmd_i.emit_found || cmd_i.emit_none) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.adv_init) begin
        adv_steps_q <= '0;
      end else if (cmd_i.adv_count) begin
        adv_steps_q <= adv_steps_q + CountW'(1);
      end
      if (cmd_i.sw_init) begin
        sw_steps_q <= '0;
        sweep_q    <= '0;
      end else if (cmd_i.sw_next) begin
        sw_steps_q <= '0;
        sweep_q    <= sweep_q + SweepW'(1);
      end else if (cmd_i.sw_count) begin
        sw_steps_q <= sw_steps_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wrap_q <= wrap_d;
    if (cmd_i.capture) begin
      frame_q <= item_i.frame_index;
      kind_q  <= kind_e'(item_i.kind);
      wr_q    <= item_i.is_write;
      pin_q   <= item_i.pin_request;
    end
    if (cmd_i.adv_init) begin
      adv_start_q <= hand_q;
    end
    if (cmd_i.sw_init || cmd_i.sw_next) begin
      sw_start_q <= hand_q;
    end
    if (cmd_i.emit_found) begin
      res_found_q <= 1'b1;
      res_frame_q <= hand_q;
      res_dirty_q <= (ent.dirty != '0);
    end else if (cmd_i.emit_none) begin
      res_found_q <= 1'b0;
      res_frame_q <= '0;
      res_dirty_q <= 1'b0;
    end
  end

  assign item_i.ready          = cmd_i.in_ready;
  assign cfg_i.ready           = 1'b1;
  assign result_o.valid        = out_valid_q;
  assign result_o.victim_found = res_found_q;
  assign result_o.victim_frame = res_frame_q;
  assign result_o.victim_dirty = res_dirty_q;

  assign status_o.in_valid      = item_i.valid;
  assign status_o.in_kind       = kind_e'(item_i.kind);
  assign status_o.in_range      = ({1'b0, item_i.frame_index} < n);
  assign status_o.item_new      = (kind_q == KindNewPage);
  assign status_o.pinned        = ent.pin;
  assign status_o.refb          = ent.refb;
  assign status_o.dirty_nz      = (ent.dirty != '0);
  assign status_o.land          = (cand < n);
  assign status_o.land_at_start = (cand[FrameIdxW-1:0] == adv_start_q);
  assign status_o.adv_last      = ((adv_steps_q + CountW'(1)) >= n);
  assign status_o.sw_at_start   = (hand_q == sw_start_q);
  assign status_o.sw_last       = ((sw_steps_q + CountW'(1)) >= n);
  assign status_o.last_sweep    = (sweep_q == SweepW'(LastSweep));
  assign status_o.out_full      = out_valid_q;

  // A new result may only be loaded into an empty output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_found || cmd_i.emit_none) |-> !out_valid_q)
    else $error("result emitted while output register is full");

  // The state RAM is never written in a cycle that also reads it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !cmd_i.rd_en)
    else $error("state RAM read and written in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.emit_found, cmd_i.emit_none, cmd_i.wr_item, cmd_i.wr_clear_ref}))
    else $error("conflicting result and write commands");

  // The output word only appears after an emit command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.emit_found || cmd_i.emit_none))
    else $error("result valid without an emit");

endmodule

// File: design/clock_replacement_with_dirty_pass_core.sv
// ----------------------------------------------------------------------------
// clock_replacement_with_dirty_pass_core
// Clock (second chance) frame replacement with a dirty-aware victim search.
//
// Items are taken one at a time. An item whose frame is outside the frame
// count is dropped in its accept cycle. Access and unpin read the frame
// state and write it back. A new page does the same and then advances the
// hand past pinned frames until it lands on an unpinned frame or returns to
// its start. When the hand sits above a lowered frame count, the first step
// repeats its wrap subtraction until the hand is in range. A victim search
// walks up to three sweeps of up to frames_in_use hand steps. At its slowest,
// the hand sits on a pinned frame and a single unpinned frame is left.
// Then every step circles all frames. The single read port of the frame
// state RAM sets the pace of the search. The only result is the victim word.
// The next item is accepted while it waits, but a second search stalls at
// its result until it is taken. Frame state needs no clearing pass after
// reset: per-frame valid bits make unwritten frames read as zero.
// ----------------------------------------------------------------------------
module clock_replacement_with_dirty_pass_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  crdp_item_if.sink     item_i,
  crdp_result_if.source result_o,
  crdp_cfg_if.sink      cfg_i
);
  import crdp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  crdp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .cmd_o   (cmd)
  );

  crdp_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .result_o(result_o),
    .cfg_i   (cfg_i),
    .cmd_i   (cmd),
    .status_o(status)
  );

endmodule
